/* sv/lge_pkg.sv */
package lge_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int CELL_W        = 64;
  localparam int ROW_IDX_W     = 6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [ROW_IDX_W-1:0] row_index;
    logic [CELL_W-1:0]    row_cells;
  } in_item_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] out_row_index;
    logic [CELL_W-1:0]    out_row_cells;
    logic                 last_row;
  } out_item_t;

  typedef struct packed {
    logic                 ld_en;
    logic                 rd_en;
    logic [ROW_IDX_W-1:0] rd_addr;
    logic                 win_init;
    logic                 advance;
    logic [ROW_IDX_W-1:0] row;
    logic                 last;
  } dp_cmd_t;

endpackage

/* sv/lge_ctrl.sv */
module lge_ctrl #(
  parameter int GRID_SIZE = lge_pkg::GRID_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lge_pkg::in_item_t in_item,
  output logic              busy,
  output lge_pkg::dp_cmd_t  dp_cmd
);
  import lge_pkg::*;

  localparam int AW      = $clog2(GRID_SIZE);
  localparam int AHEAD_W = ROW_IDX_W + 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIZE - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      row_r, row_nxt;
  logic [AHEAD_W-1:0] row_ahead;
  logic               in_range;

  assign row_ahead = AHEAD_W'(row_r) + AHEAD_W'(2);
  assign in_range  = AHEAD_W'(in_item.row_index) < AHEAD_W'(GRID_SIZE);
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    dp_cmd    = '0;
    dp_cmd.row  = ROW_IDX_W'(row_r);
    dp_cmd.last = (row_r == LAST_ROW);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.command == CMD_STEP) begin
            dp_cmd.rd_en   = 1'b1;
            dp_cmd.rd_addr = '0;
            state_nxt      = ST_FILL;
          end else if (in_range) begin
            dp_cmd.ld_en = 1'b1;
          end
        end
      end
      ST_FILL: begin
        dp_cmd.rd_en    = 1'b1;
        dp_cmd.rd_addr  = ROW_IDX_W'(1);
        dp_cmd.win_init = 1'b1;
        row_nxt         = '0;
        state_nxt       = ST_RUN;
      end
      ST_RUN: begin
        dp_cmd.advance = 1'b1;
        dp_cmd.rd_en   = (row_ahead < AHEAD_W'(GRID_SIZE));
        dp_cmd.rd_addr = row_ahead[ROW_IDX_W-1:0];
        if (row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

/* sv/lge_datapath.sv */
module lge_datapath #(
  parameter int GRID_SIZE = lge_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lge_pkg::in_item_t  in_item,
  input  lge_pkg::dp_cmd_t   dp_cmd,
  output logic               out_valid,
  output lge_pkg::out_item_t out_item
);
  import lge_pkg::*;

  localparam int AW = $clog2(GRID_SIZE);
  localparam logic [CELL_W-1:0] COL_MASK = {CELL_W{1'b1}} >> (CELL_W - GRID_SIZE);

  function automatic logic [CELL_W-1:0] next_row(input logic [CELL_W-1:0] above,
                                                 input logic [CELL_W-1:0] cur,
                                                 input logic [CELL_W-1:0] below);
    logic [CELL_W-1:0] a_l, a_r, c_l, c_r, b_l, b_r, res;
    logic [3:0]        cnt;
    a_l = above << 1;
    a_r = above >> 1;
    c_l = cur << 1;
    c_r = cur >> 1;
    b_l = below << 1;
    b_r = below >> 1;
    res = '0;
    for (int c = 0; c < CELL_W; c++) begin
      cnt = 4'(a_l[c]) + 4'(above[c]) + 4'(a_r[c]) + 4'(c_l[c]) + 4'(c_r[c])
          + 4'(b_l[c]) + 4'(below[c]) + 4'(b_r[c]);
      res[c] = (cnt == 4'd3) || (cur[c] && (cnt == 4'd2));
    end
    return res;
  endfunction

  logic [CELL_W-1:0]    mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] valid_r;
  logic [CELL_W-1:0]    rd_raw_r;
  logic                 rd_vld_r;
  logic [CELL_W-1:0]    above_r, cur_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [CELL_W-1:0]    rd_row, below, fresh, wr_data;
  logic [ROW_IDX_W-1:0] wr_addr;
  logic                 wr_en;

  assign rd_row  = rd_vld_r ? rd_raw_r : '0;
  assign below   = dp_cmd.last ? '0 : rd_row;
  assign fresh   = next_row(above_r, cur_r, below) & COL_MASK;
  assign wr_en   = dp_cmd.ld_en | dp_cmd.advance;
  assign wr_addr = dp_cmd.ld_en ? in_item.row_index : dp_cmd.row;
  assign wr_data = dp_cmd.ld_en ? (in_item.row_cells & COL_MASK) : fresh;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (dp_cmd.rd_en) begin
      rd_raw_r <= mem[dp_cmd.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr[AW-1:0]] <= 1'b1;
      end
      if (dp_cmd.rd_en) begin
        rd_vld_r <= valid_r[dp_cmd.rd_addr[AW-1:0]];
      end
      out_valid_r <= dp_cmd.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.win_init) begin
      above_r <= '0;
      cur_r   <= rd_row;
    end else if (dp_cmd.advance) begin
      above_r <= cur_r;
      cur_r   <= below;
    end
    if (dp_cmd.advance) begin
      out_item_r.out_row_index <= dp_cmd.row;
      out_item_r.out_row_cells <= fresh;
      out_item_r.last_row      <= dp_cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/life_generation_engine_core.sv */
// Conway life engine (B3/S23) on a GRID_SIZE x GRID_SIZE grid, all dead after reset, no
// wrap-around at the edges. A load command is taken and busy stays low, so loads may
// follow back to back. A step command raises busy through a fill state, which loads the
// first row into the window, and a run state that yields one row per cycle, set by the
// single read port of the row memory. Rows 0 to GRID_SIZE-1 of the new generation appear
// on out_item on consecutive cycles, each registered and marked by out_valid for one cycle,
// last_row on the final one. The receiver cannot stall: every row must be taken in the
// cycle it is shown. A new command may be taken while the final row is shown.
module life_generation_engine_core #(
  parameter int GRID_SIZE = lge_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lge_pkg::in_item_t  in_item,
  output logic               out_valid,
  output lge_pkg::out_item_t out_item
);
  import lge_pkg::*;

  dp_cmd_t dp_cmd;

  lge_ctrl #(
    .GRID_SIZE(GRID_SIZE)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .dp_cmd (dp_cmd)
  );

  lge_datapath #(
    .GRID_SIZE(GRID_SIZE)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .dp_cmd   (dp_cmd),
    .out_valid(out_valid),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_out_only_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("row transfer without a running step");

  a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_row |=> out_valid &&
      (out_item.out_row_index == ROW_IDX_W'($past(out_item.out_row_index) + 6'd1)))
    else $error("row transfers not consecutive");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_row |=> !out_valid)
    else $error("row transfer after last row");

  a_no_write_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.ld_en |-> !busy && !dp_cmd.advance)
    else $error("load write while step running");
`endif

endmodule
